### sv/utfvc_pkg.sv
// utfvc_pkg: shared types, constants and the whitespace test of the utf-8 validator
// no dependencies; used by utfvc_result_if, the decoder and the top level
package utfvc_pkg;

    localparam int MAX_BYTES = 1024;
    localparam int COUNT_W = 11;
    localparam int CP_W = 21;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // character count saturates at the buffer size or the field limit
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_BYTES < 2047) ? COUNT_W'(MAX_BYTES) : COUNT_W'(2047);

    localparam logic [7:0] ASCII_MAX  = 8'h7f;
    localparam logic [7:0] LEAD2_MIN  = 8'hc2;
    localparam logic [7:0] LEAD2_MAX  = 8'hdf;
    localparam logic [7:0] LEAD3_MIN  = 8'he0;
    localparam logic [7:0] LEAD3_MAX  = 8'hef;
    localparam logic [7:0] LEAD4_MIN  = 8'hf0;
    localparam logic [7:0] LEAD4_MAX  = 8'hf4;
    localparam logic [7:0] LEAD_SURR  = 8'hed;
    localparam logic [7:0] LIM_E0     = 8'ha0;
    localparam logic [7:0] LIM_F0     = 8'h90;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    typedef enum logic [1:0] {
        REG_MIN_CHARS       = 2'd0,
        REG_MAX_CHARS       = 2'd1,
        REG_REQUIRE_VISIBLE = 2'd2,
        REG_NONE            = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]         bytes_pending;
        logic [2:0]         seq_length;
        logic [7:0]         lead_value;
        logic [CP_W-1:0]    code_accum;
        logic               error_seen;
        logic [COUNT_W-1:0] count_so_far;
        logic               visible_seen;
    } str_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] min_chars;
        logic [COUNT_W-1:0] max_chars;
        logic               require_visible;
    } cfg_t;

    typedef struct packed {
        logic               is_valid;
        logic [COUNT_W-1:0] char_count;
        logic               has_visible;
        logic               accepted;
    } result_t;

    function automatic logic is_space_cp(input logic [CP_W-1:0] cp);
        return cp inside {[21'h00009 : 21'h0000d], 21'h00020, 21'h00085, 21'h000a0,
                          21'h01680, [21'h02000 : 21'h0200a], 21'h02028, 21'h02029,
                          21'h0202f, 21'h0205f, 21'h03000};
    endfunction

endpackage

### sv/utfvc_if.sv
// utfvc_byte_if and utfvc_result_if: valid/ready channels of the utf-8 validator
// depends on utfvc_pkg for the count width
interface utfvc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

interface utfvc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          is_valid;
    logic [utfvc_pkg::COUNT_W-1:0] char_count;
    logic                          has_visible;
    logic                          accepted;

    modport source (output valid, output is_valid, output char_count,
                    output has_visible, output accepted, input ready);
    modport sink (input valid, input is_valid, input char_count,
                  input has_visible, input accepted, output ready);
endinterface

### sv/utf8_validate_count_core.sv
// utf8_validate_count_core: strict utf-8 validator and character counter, top level
// the byte with last is taken into the input register, then its result into the result register
// throughput: one byte per cycle while the result is not stalled, set by the single decode step
//   between the input register and the result register; a stalled result still lets one byte in
// reset: rst_n clears the string state and valid flags at once and loads the register
//   defaults (min 1, max 80, visible required); no clearing pass
// depends on utfvc_pkg, utfvc_if and utfvc_decode
module utf8_validate_count_core (
    input  logic                            clk,
    input  logic                            rst_n,
    utfvc_byte_if.sink                      stream,
    utfvc_result_if.source                  result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [utfvc_pkg::PADDR_W-1:0]   paddr,
    input  logic [utfvc_pkg::PDATA_W-1:0]   pwdata,
    output logic [utfvc_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_has_reg;
    logic                  in_last_reg;
    logic                  advance;

    utfvc_pkg::str_state_t st_reg;
    utfvc_pkg::str_state_t st_next;
    utfvc_pkg::result_t    res_next;
    utfvc_pkg::result_t    res_reg;
    logic                  out_valid_reg;

    utfvc_pkg::cfg_t       cfg_reg;
    utfvc_pkg::reg_index_t reg_sel;
    logic                  cfg_write;

    // config port
    assign pready    = 1'b1;
    assign reg_sel   = utfvc_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_chars       <= utfvc_pkg::COUNT_W'(1);
            cfg_reg.max_chars       <= utfvc_pkg::COUNT_W'(80);
            cfg_reg.require_visible <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                utfvc_pkg::REG_MIN_CHARS:
                    cfg_reg.min_chars <= pwdata[utfvc_pkg::COUNT_W-1:0];
                utfvc_pkg::REG_MAX_CHARS:
                    cfg_reg.max_chars <= pwdata[utfvc_pkg::COUNT_W-1:0];
                utfvc_pkg::REG_REQUIRE_VISIBLE:
                    cfg_reg.require_visible <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            utfvc_pkg::REG_MIN_CHARS:
                prdata = {{(utfvc_pkg::PDATA_W-utfvc_pkg::COUNT_W){1'b0}}, cfg_reg.min_chars};
            utfvc_pkg::REG_MAX_CHARS:
                prdata = {{(utfvc_pkg::PDATA_W-utfvc_pkg::COUNT_W){1'b0}}, cfg_reg.max_chars};
            utfvc_pkg::REG_REQUIRE_VISIBLE:
                prdata = {{(utfvc_pkg::PDATA_W-1){1'b0}}, cfg_reg.require_visible};
            default:
                prdata = '0;
        endcase
    end

    // input register; it moves on whenever the result register can take a result
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.data_byte;
            in_has_reg  <= stream.has_byte;
            in_last_reg <= stream.last;
        end
    end

    utfvc_decode u_decode (
        .st        (st_reg),
        .cfg       (cfg_reg),
        .data_byte (in_byte_reg),
        .has_byte  (in_has_reg),
        .last      (in_last_reg),
        .st_next   (st_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.is_valid    = res_reg.is_valid;
    assign result.char_count  = res_reg.char_count;
    assign result.has_visible = res_reg.has_visible;
    assign result.accepted    = res_reg.accepted;

`ifndef SYNTHESIS
    a_accept_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.accepted || result.is_valid))
        else $error("accepted flag set on an invalid string");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.count_so_far <= utfvc_pkg::COUNT_CAP)
        else $error("character count above its cap");

    a_visible_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.visible_seen |-> (st_reg.count_so_far != '0))
        else $error("visible flag without a counted character");

    a_pending_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.bytes_pending != 2'd0) |->
            (st_reg.seq_length > {1'b0, st_reg.bytes_pending}))
        else $error("continuation count outside the current sequence");

    a_error_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.error_seen && advance && !in_last_reg) |=>
            ($stable(st_reg.count_so_far) && st_reg.error_seen))
        else $error("count moved after an error");
`endif

endmodule

### sv/utfvc_decode.sv
// utfvc_decode: one-byte step of the utf-8 validator, string state in, next state out
// depends on utfvc_pkg for the state, config and result types
module utfvc_decode (
    input  utfvc_pkg::str_state_t st,
    input  utfvc_pkg::cfg_t       cfg,
    input  logic [7:0]            data_byte,
    input  logic                  has_byte,
    input  logic                  last,
    output utfvc_pkg::str_state_t st_next,
    output utfvc_pkg::result_t    res
);

    utfvc_pkg::str_state_t      s;
    logic                       done;
    logic [utfvc_pkg::CP_W-1:0] cp;
    logic [utfvc_pkg::CP_W-1:0] acc_shift;
    logic [1:0]                 pend_dec;
    logic                       first_cont;
    logic                       bad_second;
    logic                       err_end;

    assign acc_shift  = {st.code_accum[utfvc_pkg::CP_W-7:0], data_byte[5:0]};
    assign pend_dec   = st.bytes_pending - 2'd1;
    assign first_cont = (st.seq_length == ({1'b0, st.bytes_pending} + 3'd1));
    // overlong, surrogate and above-limit forms show in the first continuation byte
    assign bad_second = ((st.lead_value == utfvc_pkg::LEAD3_MIN) &&
                         (data_byte < utfvc_pkg::LIM_E0)) ||
                        ((st.lead_value == utfvc_pkg::LEAD_SURR) &&
                         (data_byte >= utfvc_pkg::LIM_E0)) ||
                        ((st.lead_value == utfvc_pkg::LEAD4_MIN) &&
                         (data_byte < utfvc_pkg::LIM_F0)) ||
                        ((st.lead_value == utfvc_pkg::LEAD4_MAX) &&
                         (data_byte >= utfvc_pkg::LIM_F0));

    always_comb
    begin
        s    = st;
        done = 1'b0;
        cp   = '0;
        if (has_byte && !st.error_seen)
        begin
            if (st.bytes_pending == 2'd0)
            begin
                s.lead_value = data_byte;
                if (data_byte <= utfvc_pkg::ASCII_MAX)
                begin
                    done = 1'b1;
                    cp   = {13'd0, data_byte};
                end
                else if (data_byte inside {[utfvc_pkg::LEAD2_MIN : utfvc_pkg::LEAD2_MAX]})
                begin
                    s.seq_length    = 3'd2;
                    s.bytes_pending = 2'd1;
                    s.code_accum    = {16'd0, data_byte[4:0]};
                end
                else if (data_byte inside {[utfvc_pkg::LEAD3_MIN : utfvc_pkg::LEAD3_MAX]})
                begin
                    s.seq_length    = 3'd3;
                    s.bytes_pending = 2'd2;
                    s.code_accum    = {17'd0, data_byte[3:0]};
                end
                else if (data_byte inside {[utfvc_pkg::LEAD4_MIN : utfvc_pkg::LEAD4_MAX]})
                begin
                    s.seq_length    = 3'd4;
                    s.bytes_pending = 2'd3;
                    s.code_accum    = {18'd0, data_byte[2:0]};
                end
                else
                begin
                    s.error_seen = 1'b1;
                end
            end
            else if (data_byte[7:6] != utfvc_pkg::CONT_TAG)
            begin
                s.error_seen = 1'b1;
            end
            else if (first_cont && bad_second)
            begin
                s.error_seen = 1'b1;
            end
            else
            begin
                s.code_accum    = acc_shift;
                s.bytes_pending = pend_dec;
                if (pend_dec == 2'd0)
                begin
                    done = 1'b1;
                    cp   = acc_shift;
                end
            end
        end

        if (done)
        begin
            if (s.count_so_far < utfvc_pkg::COUNT_CAP)
            begin
                s.count_so_far = s.count_so_far + utfvc_pkg::COUNT_W'(1);
            end
            if (!utfvc_pkg::is_space_cp(cp))
            begin
                s.visible_seen = 1'b1;
            end
            s.seq_length = 3'd0;
        end

        // earlier error or truncated sequence at the end of the string
        err_end         = s.error_seen || (s.bytes_pending != 2'd0);
        res.is_valid    = !err_end;
        res.char_count  = s.count_so_far;
        res.has_visible = s.visible_seen;
        res.accepted    = !err_end && (s.count_so_far >= cfg.min_chars) &&
                          (s.count_so_far <= cfg.max_chars) &&
                          (!cfg.require_visible || s.visible_seen);

        st_next = last ? '0 : s;
    end

endmodule
